[rtl/tfvr_pkg.sv]
// Shared widths, register indexes and reset values for the throttle
// filter and voltage ramp block. No dependencies.
package tfvr_pkg;

    // Raw ADC word and Q15 widths
    localparam int RAW_W   = 16;
    localparam int Q15_W   = 15;
    localparam int CMD_W   = 16;
    localparam int ALPHA_W = 15;
    localparam int STEP_W  = 10;
    localparam int LIMIT_W = 15;

    localparam int SAMPLE_BITS_DEF = 16;

    // Stream payload widths (padded to whole bytes)
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_ENABLE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_THRESHOLD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRE_OBSERVER = 3'd5;

    localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST   = 15'd3277;
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST      = 10'd50;
    localparam logic               CLAMP_ENABLE_RST   = 1'b1;
    localparam logic [LIMIT_W-1:0] VOLTAGE_LIMIT_RST  = 15'd15000;
    localparam logic [Q15_W-1:0]   STOP_THRESHOLD_RST = 15'd2000;
    localparam logic               REQUIRE_OBS_RST    = 1'b0;

    // Output tdata bit positions of the two stop flags
    localparam int OUT_STOP_BIT   = 62;
    localparam int OUT_ENABLE_BIT = 63;

endpackage

[rtl/tfvr_lpf.sv]
// One Q15 first-order low-pass channel with its own state register.
// Depends on tfvr_pkg.
module tfvr_lpf #(
    parameter int SAMPLE_BITS = tfvr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [SAMPLE_BITS-1:0]       raw,
    input  logic [tfvr_pkg::ALPHA_W-1:0] alpha,
    output logic [tfvr_pkg::Q15_W-1:0]   y
);
    import tfvr_pkg::*;

    logic [RAW_W-1:0]       raw_left;
    logic [Q15_W-1:0]       x_q15;
    logic signed [Q15_W:0]  diff;
    logic signed [31:0]     prod;
    logic signed [31:0]     prod_rnd;
    logic signed [Q15_W+1:0] delta;
    logic signed [Q15_W+1:0] y_sum;
    logic [Q15_W-1:0]       y_reg;
    logic [Q15_W-1:0]       y_next;

    // Left-align the sample, then halve into Q15
    assign raw_left = RAW_W'(raw) << (RAW_W - SAMPLE_BITS);
    assign x_q15    = raw_left[RAW_W-1:1];

    // y = prev + round(alpha * (x - prev) / 2^15), same as the weighted sum form
    assign diff     = $signed({1'b0, x_q15}) - $signed({1'b0, y_reg});
    assign prod     = $signed({1'b0, alpha}) * diff;
    assign prod_rnd = prod + 32'sd16384;
    assign delta    = (Q15_W+2)'(prod_rnd >>> 15);
    assign y_sum    = $signed({2'b00, y_reg}) + delta;
    assign y_next   = y_sum[Q15_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg <= '0;
        end
        else if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

[rtl/throttle_filter_voltage_ramp_top.sv]
// Throttle, brake and bus-voltage conditioning with a slewed q-axis voltage
// command. Depends on tfvr_pkg and tfvr_lpf.
//
//  Channel  | Direction | Handshake          | Contents
//  ---------+-----------+--------------------+------------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | three raw ADC words + motor flags
//  m_axis   | out       | m_tvalid/m_tready  | three filtered words, command, flags
//  cfg      | in        | cfg_we             | six registers, write only
//
// Three register stages: input register, filter stage (holds filter state),
// result register (ramp, clamp and stop test). One transaction can be
// accepted every cycle while the output is not stalled. The filter recurrence
// closes in the filter stage, the command recurrence in the ramp stage. Reset
// clears valids, filter and command state, and loads the default register
// values. A stall on the output fills empty stages first; s_tready falls only
// when all three hold.
module throttle_filter_voltage_ramp_top #(
    parameter int SAMPLE_BITS = tfvr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: throttle_raw[15:0], brake_raw[31:16], vbus_raw[47:32],
    //          motor_running[48], motor_stopped[49], observer_locked[50], zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tfvr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // m_tdata: throttle_filtered[14:0], brake_filtered[29:15],
    //          vbus_filtered[44:30], voltage_command[60:45],
    //          current_ref_clear[61], stop_request[62], motor_enable[63]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tfvr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                              cfg_we,
    input  logic [tfvr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfvr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tfvr_pkg::*;

    // ---------------- configuration registers ----------------
    logic [ALPHA_W-1:0] alpha_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               clamp_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [Q15_W-1:0]   thresh_reg;
    logic               req_obs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= FILTER_ALPHA_RST;
            step_reg    <= RAMP_STEP_RST;
            clamp_reg   <= CLAMP_ENABLE_RST;
            limit_reg   <= VOLTAGE_LIMIT_RST;
            thresh_reg  <= STOP_THRESHOLD_RST;
            req_obs_reg <= REQUIRE_OBS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_ALPHA:     alpha_reg   <= cfg_data[ALPHA_W-1:0];
                REG_RAMP_STEP:        step_reg    <= cfg_data[STEP_W-1:0];
                REG_CLAMP_ENABLE:     clamp_reg   <= cfg_data[0];
                REG_VOLTAGE_LIMIT:    limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_STOP_THRESHOLD:   thresh_reg  <= cfg_data[Q15_W-1:0];
                REG_REQUIRE_OBSERVER: req_obs_reg <= cfg_data[0];
                default:              ; // unused indexes: drop the write
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic v0_reg, v1_reg, out_v_reg;
    logic en_out;   // filter stage -> result register
    logic en_flt;   // input register -> filter stage
    logic accept;

    assign en_out   = v1_reg && (!out_v_reg || m_tready);
    assign en_flt   = v0_reg && (!v1_reg || en_out);
    assign s_tready = !v0_reg || en_flt;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                v0_reg <= 1'b1;
            else if (en_flt)
                v0_reg <= 1'b0;

            if (en_flt)
                v1_reg <= 1'b1;
            else if (en_out)
                v1_reg <= 1'b0;

            if (en_out)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    // ---------------- input register ----------------
    logic [SAMPLE_BITS-1:0] thr_raw_reg, brk_raw_reg, vbus_raw_reg;
    logic                   run0_reg, stp0_reg, lck0_reg;

    // Only the low SAMPLE_BITS of each word carry information
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            thr_raw_reg  <= s_tdata[SAMPLE_BITS-1:0];
            brk_raw_reg  <= s_tdata[RAW_W+SAMPLE_BITS-1:RAW_W];
            vbus_raw_reg <= s_tdata[2*RAW_W+SAMPLE_BITS-1:2*RAW_W];
            run0_reg     <= s_tdata[3*RAW_W];
            stp0_reg     <= s_tdata[3*RAW_W+1];
            lck0_reg     <= s_tdata[3*RAW_W+2];
        end
    end

    // ---------------- filter stage ----------------
    // The filter state registers are the stage payload.
    logic [Q15_W-1:0] thr_f, brk_f, vbus_f;
    logic             run1_reg, stp1_reg, lck1_reg;

    tfvr_lpf #(.SAMPLE_BITS(SAMPLE_BITS)) u_lpf_thr (
        .clk(clk), .rst_n(rst_n), .en(en_flt), .raw(thr_raw_reg),
        .alpha(alpha_reg), .y(thr_f)
    );
    tfvr_lpf #(.SAMPLE_BITS(SAMPLE_BITS)) u_lpf_brk (
        .clk(clk), .rst_n(rst_n), .en(en_flt), .raw(brk_raw_reg),
        .alpha(alpha_reg), .y(brk_f)
    );
    tfvr_lpf #(.SAMPLE_BITS(SAMPLE_BITS)) u_lpf_vbus (
        .clk(clk), .rst_n(rst_n), .en(en_flt), .raw(vbus_raw_reg),
        .alpha(alpha_reg), .y(vbus_f)
    );

    always_ff @(posedge clk)
    begin
        if (en_flt)
        begin
            run1_reg <= run0_reg;
            stp1_reg <= stp0_reg;
            lck1_reg <= lck0_reg;
        end
    end

    // ---------------- ramp stage ----------------
    logic signed [CMD_W-1:0] cmd_reg;
    logic signed [CMD_W-1:0] cmd_next;
    logic signed [CMD_W+1:0] cmd_wide;
    logic signed [CMD_W+1:0] stepped;
    logic signed [CMD_W+1:0] clamped;
    logic signed [CMD_W+1:0] lim_pos;
    logic signed [CMD_W+1:0] lim_neg;
    logic signed [CMD_W+1:0] target;
    logic signed [CMD_W+1:0] step_s;
    logic                    ramp_on;
    logic                    stop;

    assign ramp_on  = run1_reg && (!req_obs_reg || lck1_reg);
    assign cmd_wide = (CMD_W+2)'(cmd_reg);
    assign target   = $signed({3'b000, thr_f});
    assign step_s   = $signed({8'b0, step_reg});
    assign lim_pos  = $signed({3'b000, limit_reg});
    assign lim_neg  = -lim_pos;

    // Step toward the filtered throttle; a short distance still takes a full step
    always_comb
    begin
        priority if (target > cmd_wide)
            stepped = cmd_wide + step_s;
        else if (target < cmd_wide)
            stepped = cmd_wide - step_s;
        else
            stepped = cmd_wide;
    end

    // Optional clamp to +/- limit, then int16 saturation
    always_comb
    begin
        clamped = stepped;
        if (clamp_reg)
        begin
            priority if (stepped > lim_pos)
                clamped = lim_pos;
            else if (stepped < lim_neg)
                clamped = lim_neg;
        end
        priority if (clamped > 18'sd32767)
            cmd_next = 16'sh7FFF;
        else if (clamped < -18'sd32768)
            cmd_next = 16'sh8000;
        else
            cmd_next = clamped[CMD_W-1:0];
    end

    assign stop = (thr_f < thresh_reg) && !stp1_reg;

    // Command state: hold unless ramping runs on this transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_reg <= '0;
        else if (en_out && ramp_on)
            cmd_reg <= cmd_next;
    end

    // ---------------- result register ----------------
    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_data_reg <= {!stop, stop, ramp_on,
                             (ramp_on ? cmd_next : cmd_reg),
                             vbus_f, brk_f, thr_f};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/tfvr_checker.sv]
// Port-level checks for the throttle filter and voltage ramp block, with the
// bind that attaches them to the top level. Depends on tfvr_pkg.
module tfvr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tfvr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tfvr_pkg::*;

    // A stalled result transaction holds its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // A stalled result transaction stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // With the result register empty the pipeline must take new input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    // While m_tvalid is high, motor enable is the inverse of the stop request
    a_enable_vs_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_ENABLE_BIT] != m_tdata[OUT_STOP_BIT]))
        else $error("motor_enable and stop_request disagree");

endmodule

bind throttle_filter_voltage_ramp_top tfvr_checker u_tfvr_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

[bench/tfvr_conditioning_checker.sv]
// Checker for the throttle filter and voltage ramp block: mirrors the
// configuration writes, predicts each result and compares it field by field.
// Depends on tfvr_pkg.
module tfvr_conditioning_checker #(
    parameter int SAMPLE_BITS = tfvr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: throttle_raw, brake_raw, vbus_raw, motor_running,
    //          motor_stopped, observer_locked, zero pad
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [tfvr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // m_tdata: throttle_filtered, brake_filtered, vbus_filtered,
    //          voltage_command, current_ref_clear, stop_request, motor_enable
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tfvr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [tfvr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfvr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                pending_results
);
    import tfvr_pkg::*;

    typedef struct packed {
        logic [Q15_W-1:0]        throttle;
        logic [Q15_W-1:0]        brake;
        logic [Q15_W-1:0]        vbus;
        logic signed [CMD_W-1:0] command;
        logic                    ref_clear;
        logic                    stop_req;
        logic                    enable;
    } cond_result_t;

    // Register mirror
    logic [ALPHA_W-1:0] alpha_q15;
    logic [STEP_W-1:0]  step_size;
    logic               clamp_on;
    logic [LIMIT_W-1:0] cmd_limit;
    logic [Q15_W-1:0]   stop_level;
    logic               need_lock;

    // Filter and command state
    logic [Q15_W-1:0]        thr_filt;
    logic [Q15_W-1:0]        brk_filt;
    logic [Q15_W-1:0]        vbus_filt;
    logic signed [CMD_W-1:0] cmd_hold;

    cond_result_t predicted_results[$];
    int           mismatches = 0;
    int           outstanding = 0;
    int           results_seen = 0;

    assign fail_count      = mismatches;
    assign pending_results = outstanding;

    function automatic logic [Q15_W-1:0] to_q15(logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0] v;
        v = raw & RAW_W'((32'd1 << SAMPLE_BITS) - 32'd1);
        v = v << (RAW_W - SAMPLE_BITS);
        return v[RAW_W-1:1];
    endfunction

    function automatic logic [Q15_W-1:0] lowpass(logic [Q15_W-1:0] prev,
                                                 logic [Q15_W-1:0] x);
        longint acc;
        acc = longint'(alpha_q15) * longint'(x)
            + (longint'(32768) - longint'(alpha_q15)) * longint'(prev)
            + longint'(16384);
        return acc[29:15];
    endfunction

    // Advance the filters and the command by one sample set
    function automatic cond_result_t condition_sample(logic [IN_TDATA_W-1:0] word);
        logic         running;
        logic         stopped;
        logic         locked;
        logic         ramp_on;
        logic         stop;
        int           cmd;
        cond_result_t r;
        running = word[48];
        stopped = word[49];
        locked  = word[50];
        thr_filt  = lowpass(thr_filt,  to_q15(word[15:0]));
        brk_filt  = lowpass(brk_filt,  to_q15(word[31:16]));
        vbus_filt = lowpass(vbus_filt, to_q15(word[47:32]));
        ramp_on = running && (!need_lock || locked);
        if (ramp_on)
        begin
            cmd = int'(cmd_hold);
            // a full step even when closer than one step to the target
            if (int'(thr_filt) > cmd)
                cmd += int'(step_size);
            else if (int'(thr_filt) < cmd)
                cmd -= int'(step_size);
            if (clamp_on)
            begin
                if (cmd > int'(cmd_limit))
                    cmd = int'(cmd_limit);
                else if (cmd < -int'(cmd_limit))
                    cmd = -int'(cmd_limit);
            end
            if (cmd > 32767)
                cmd = 32767;
            else if (cmd < -32768)
                cmd = -32768;
            cmd_hold = CMD_W'(cmd);
        end
        stop = (thr_filt < stop_level) && !stopped;
        r.throttle  = thr_filt;
        r.brake     = brk_filt;
        r.vbus      = vbus_filt;
        r.command   = cmd_hold;
        r.ref_clear = ramp_on;
        r.stop_req  = stop;
        r.enable    = !stop;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cond_result_t want;
        cond_result_t got;
        if (!rst_n)
        begin
            alpha_q15  = FILTER_ALPHA_RST;
            step_size  = RAMP_STEP_RST;
            clamp_on   = CLAMP_ENABLE_RST;
            cmd_limit  = VOLTAGE_LIMIT_RST;
            stop_level = STOP_THRESHOLD_RST;
            need_lock  = REQUIRE_OBS_RST;
            thr_filt   = '0;
            brk_filt   = '0;
            vbus_filt  = '0;
            cmd_hold   = '0;
            predicted_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FILTER_ALPHA:     alpha_q15  = cfg_data[ALPHA_W-1:0];
                    REG_RAMP_STEP:        step_size  = cfg_data[STEP_W-1:0];
                    REG_CLAMP_ENABLE:     clamp_on   = cfg_data[0];
                    REG_VOLTAGE_LIMIT:    cmd_limit  = cfg_data[LIMIT_W-1:0];
                    REG_STOP_THRESHOLD:   stop_level = cfg_data[Q15_W-1:0];
                    REG_REQUIRE_OBSERVER: need_lock  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(condition_sample(s_tdata));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                    report_mismatch("result with nothing outstanding", m_tdata, 0);
                else
                begin
                    want = predicted_results.pop_front();
                    got.throttle  = m_tdata[14:0];
                    got.brake     = m_tdata[29:15];
                    got.vbus      = m_tdata[44:30];
                    got.command   = m_tdata[60:45];
                    got.ref_clear = m_tdata[61];
                    got.stop_req  = m_tdata[OUT_STOP_BIT];
                    got.enable    = m_tdata[OUT_ENABLE_BIT];
                    if (got.throttle !== want.throttle)
                        report_mismatch("throttle_filtered", got.throttle, want.throttle);
                    if (got.brake !== want.brake)
                        report_mismatch("brake_filtered", got.brake, want.brake);
                    if (got.vbus !== want.vbus)
                        report_mismatch("vbus_filtered", got.vbus, want.vbus);
                    if (got.command !== want.command)
                        report_mismatch("voltage_command", got.command, want.command);
                    if (got.ref_clear !== want.ref_clear)
                        report_mismatch("current_ref_clear", got.ref_clear,
                                        want.ref_clear);
                    if (got.stop_req !== want.stop_req)
                        report_mismatch("stop_request", got.stop_req, want.stop_req);
                    if (got.enable !== want.enable)
                        report_mismatch("motor_enable", got.enable, want.enable);
                end
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

[bench/throttle_filter_voltage_ramp_top_tb.sv]
// Testbench top for throttle_filter_voltage_ramp_top: drives sample sets and
// register writes, and gives the verdict from the checker's failure count.
// Depends on tfvr_pkg, tfvr_conditioning_checker and the block itself.
module throttle_filter_voltage_ramp_top_tb;
    import tfvr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CHUNK_ITEMS = 78;
    localparam int HOLD_CYCLES = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending_results;

    // Idle percentages of each side, changed per phase
    int send_idle_pct = 16;
    int recv_idle_pct = 46;
    logic hold_off = 1'b0;

    int cycle_count = 0;
    int sent_total = 0;
    int random_sent = 0;
    int settings_count = 0;
    int cur_stop = 2000;
    int thr_level = 0;

    throttle_filter_voltage_ramp_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tfvr_conditioning_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block wedges
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: randomly stall, and stall outright while the hold-off runs
    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    // Long output hold-off with the sender still offering, so the three
    // stages fill and s_tready drops
    initial
    begin
        wait (random_sent == 700);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_sample(logic [15:0] thr,
                                                          logic [15:0] brk,
                                                          logic [15:0] vb,
                                                          logic run,
                                                          logic stp,
                                                          logic lck);
        return {5'b0, lck, stp, run, vb, brk, thr};
    endfunction

    // Throttle moves like a real lever: mostly small jitter around a level,
    // now and then a jump to a new one (anywhere, rails, low end, high end, near the stop level)
    function automatic logic [15:0] next_throttle();
        int v;
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(4))
                0: thr_level = $urandom_range(65535);
                1: thr_level = $urandom_range(1) ? 65535 : 0;
                2: thr_level = $urandom_range(8191);
                3: thr_level = 2 * cur_stop + $urandom_range(1023) - 512;
                default: thr_level = 65535 - $urandom_range(8191);
            endcase
        end
        v = thr_level + $urandom_range(127) - 64;
        if (v < 0)
            v = 0;
        else if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // Offer one transaction and hold it until it is taken
    task automatic send_item(logic [IN_TDATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_total++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write enable stays high across a burst of writes; the caller drops it
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic set_registers(int alpha, int step, int clamp, int limit,
                                 int stop_lvl, int obs);
        drain_results();
        write_reg(REG_FILTER_ALPHA, alpha);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_CLAMP_ENABLE, clamp);
        write_reg(REG_VOLTAGE_LIMIT, limit);
        write_reg(REG_STOP_THRESHOLD, stop_lvl);
        write_reg(REG_REQUIRE_OBSERVER, obs);
        cfg_we <= 1'b0;
        cur_stop = stop_lvl;
        settings_count++;
    endtask

    initial
    begin
        logic [15:0] brk;
        logic [15:0] vb;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: ramp disabled with stop request, full scale ramping,
        // and a sample flagged with the motor already stopped
        send_item(pack_sample(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_item(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1));
        send_item(pack_sample(16'hFFFF, 16'h0001, 16'h8000, 1'b1, 1'b1, 1'b0));

        // Fastest filter, largest step, clamp off, observer lock required
        set_registers(32767, 1023, 0, 32767, 32767, 1);
        send_item(pack_sample(16'hFFFF, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0));
        repeat (4)
            send_item(pack_sample(16'hFFFF, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b1));
        send_item(pack_sample(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1));

        // Alpha zero holds every filter; zero limit pins the command at zero
        set_registers(0, 1, 1, 0, 0, 0);
        repeat (4)
            send_item(pack_sample(16'($urandom), 16'($urandom), 16'($urandom),
                                  1'b1, 1'b0, 1'b0));

        // Command driven below zero to the negative limit, then dithering
        // around a target closer than one step
        set_registers(32767, 700, 1, 100, 16384, 0);
        send_item(pack_sample(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0));
        send_item(pack_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0));
        send_item(pack_sample(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0));
        send_item(pack_sample(16'h0002, 16'h0001, 16'h0001, 1'b1, 1'b0, 1'b1));
        send_item(pack_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 1'b0));
        send_item(pack_sample(16'h8001, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));

        // Random part: three idle mixes, each over several register settings;
        // the first setting of each phase is an extreme one
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 16 : 0;
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                if (chunk != 0)
                    set_registers($urandom_range(32767), $urandom_range(1023),
                                  $urandom_range(1), $urandom_range(32767),
                                  $urandom_range(32767), $urandom_range(1));
                else if (phase == 0)
                    set_registers(32767, 1023, 0, 0, 32767, 1);
                else if (phase == 1)
                    set_registers(1, 1, 1, 32767, 0, 0);
                else
                    set_registers(16384, 1023, 0, 32767, 32767, 0);
                for (int n = 0; n < CHUNK_ITEMS; n++)
                begin
                    brk = 16'($urandom);
                    vb  = 16'($urandom);
                    send_item(pack_sample(next_throttle(), brk, vb,
                                          $urandom_range(3) != 0,
                                          1'($urandom_range(1)),
                                          $urandom_range(3) != 0));
                    random_sent++;
                end
            end
        end

        // Let the pipeline empty, then allow a little slack for stray results
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d sample sets over %0d register settings,", sent_total,
                 settings_count);
        $display("under three idle mixes and one long output hold-off.");
        if (fail_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
